>>> hw/rtl/gmsst_pkg.sv
`default_nettype none

package gmsst_pkg;

  localparam int KIND_W = 2;
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_EMPTY  = 2'd0;
  localparam kind_t KIND_FRESH  = 2'd1;
  localparam kind_t KIND_ROTTEN = 2'd2;

  localparam int DIST_W = 8;
  typedef logic [DIST_W-1:0] dist_t;
  localparam dist_t DIST_MAX = 8'hFF;

  localparam int MINUTES_W = 9;
  localparam logic [MINUTES_W-1:0] MINUTES_FAIL = 9'h1FF;

  localparam int CFG_W = 5;
  typedef logic [CFG_W-1:0] cfg_data_t;
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GRID_ROWS = 1'b0;
  localparam cfg_idx_t CFG_GRID_COLS = 1'b1;
  localparam cfg_data_t CFG_SIZE_RESET = 5'd16;

  typedef enum logic [2:0] {
    PH_LOAD,
    PH_INIT,
    PH_SETTLE,
    PH_SPREAD,
    PH_REDUCE,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic  load_we;
    logic  init;
    logic  spread;
    dist_t step_dist;
  } cell_ctrl_t;

  typedef struct packed {
    logic  bad;
    dist_t worst;
  } acc_t;

endpackage

`default_nettype wire

>>> hw/rtl/grid_multi_source_spread_time.sv
// Multi-source spread time on a 4-neighbor grid.
// Cells enter on the input channel (in_valid / in_stall) in row-major order,
// one request per cycle while in_stall is low, each carrying a cell kind and
// a last-cell flag. After the last cell the block stalls the input and
// computes the largest shortest distance from any fresh cell to a rotten
// one, or -1 if some fresh cell cannot be reached. The single result leaves
// on out_valid / out_stall. Grid size comes from cfg registers 0 (rows) and
// 1 (columns); the user must see that they are written only while the block
// is idle, and the block itself does not enforce this. After the last cell
// the block runs an init step, a settle check, the spread (one minute per
// cycle through the cell chain), the chained max/fail reduction and the
// result register, in that order. The settle check waits only after reset
// or a configuration write, while the column tags settle along the chain.
// Reset returns the block to loading with an empty grid and size 16x16.
// The result sits in an output register; while the receiver stalls, the
// next grid loads, and a second result waits until the first is taken.
`default_nettype none

module grid_multi_source_spread_time #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  gmsst_pkg::kind_t                       in_cell_kind,
  input  logic                                   in_last_cell,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [gmsst_pkg::MINUTES_W-1:0] out_minutes_needed,
  input  logic                                   cfg_we,
  input  gmsst_pkg::cfg_idx_t                    cfg_index,
  input  gmsst_pkg::cfg_data_t                   cfg_wdata
);
  import gmsst_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int TW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CLW   = $clog2(MAX_COLS + 1);
  localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  cfg_data_t                    grid_rows_r, grid_cols_r;
  logic [RW-1:0]                rows_c;
  logic [CLW-1:0]               cols_c;
  logic [RW+CLW-1:0]            prod;
  logic [TW-1:0]                total;
  logic [CIW-1:0]               cols_m1;
  logic [TW-1:0]                load_pos;
  cell_ctrl_t                   cell_ctrl;
  logic [CELLS-1:0]             reached_w;
  logic [CELLS+2*MAX_COLS-1:0]  reached_pad;
  logic [CIW-1:0]               col_c [CELLS];
  acc_t                         acc_c [CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= CFG_SIZE_RESET;
      grid_cols_r <= CFG_SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_GRID_ROWS) begin
        grid_rows_r <= cfg_wdata;
      end else if (cfg_index == CFG_GRID_COLS) begin
        grid_cols_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    if (grid_rows_r == '0) begin
      rows_c = RW'(1);
    end else if (int'(grid_rows_r) > MAX_ROWS) begin
      rows_c = RW'(MAX_ROWS);
    end else begin
      rows_c = RW'(grid_rows_r);
    end
    if (grid_cols_r == '0) begin
      cols_c = CLW'(1);
    end else if (int'(grid_cols_r) > MAX_COLS) begin
      cols_c = CLW'(MAX_COLS);
    end else begin
      cols_c = CLW'(grid_cols_r);
    end
    prod    = (RW+CLW)'(rows_c) * (RW+CLW)'(cols_c);
    total   = TW'(prod);
    cols_m1 = CIW'(cols_c - CLW'(1));
  end

  assign reached_pad = {{MAX_COLS{1'b0}}, reached_w, {MAX_COLS{1'b0}}};

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    logic [CIW-1:0] col_prev;
    acc_t           acc_prev;

    if (g == 0) begin : g_head
      assign col_prev = '0;
      assign acc_prev = '0;
    end else begin : g_body
      assign col_prev = col_c[g-1];
      assign acc_prev = acc_c[g-1];
    end

    gmsst_cell #(
      .IDX      (g),
      .MAX_COLS (MAX_COLS),
      .CELLS    (CELLS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .load_pos (load_pos),
      .total    (total),
      .cols_m1  (cols_m1),
      .kind_in  (in_cell_kind),
      .col_in   (col_prev),
      .col_out  (col_c[g]),
      .win      (reached_pad[g+2*MAX_COLS:g]),
      .reached  (reached_w[g]),
      .acc_in   (acc_prev),
      .acc_out  (acc_c[g])
    );
  end

  gmsst_ctrl #(
    .CELLS (CELLS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_last_cell       (in_last_cell),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_minutes_needed (out_minutes_needed),
    .cfg_we             (cfg_we),
    .total              (total),
    .load_pos           (load_pos),
    .ctrl               (cell_ctrl),
    .acc                (acc_c[CELLS-1])
  );

endmodule

`default_nettype wire

>>> hw/rtl/gmsst_cell.sv
`default_nettype none

module gmsst_cell #(
  parameter int IDX      = 0,
  parameter int MAX_COLS = 16,
  parameter int CELLS    = 256,
  localparam int TW      = $clog2(CELLS + 1),
  localparam int CIW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                   clk,
  input  gmsst_pkg::cell_ctrl_t  ctrl,
  input  logic [TW-1:0]          load_pos,
  input  logic [TW-1:0]          total,
  input  logic [CIW-1:0]         cols_m1,
  input  gmsst_pkg::kind_t       kind_in,
  input  logic [CIW-1:0]         col_in,
  output logic [CIW-1:0]         col_out,
  input  logic [2*MAX_COLS:0]    win,
  output logic                   reached,
  input  gmsst_pkg::acc_t        acc_in,
  output gmsst_pkg::acc_t        acc_out
);
  import gmsst_pkg::*;

  kind_t          kind_r;
  logic           reached_r;
  dist_t          dist_r;
  logic [CIW-1:0] col_r, col_nxt;
  acc_t           acc_r, acc_nxt;
  logic           active, fresh, rotten;
  logic           nb_up, nb_dn, nb_any, grow;

  assign active = (TW'(IDX) < load_pos) && (TW'(IDX) < total);
  assign fresh  = active && (kind_r == KIND_FRESH);
  assign rotten = active && (kind_r == KIND_ROTTEN);

  // The column tag runs along the chain and wraps at the grid width.
  always_comb begin
    if (IDX == 0) begin
      col_nxt = '0;
    end else if (col_in == cols_m1) begin
      col_nxt = '0;
    end else begin
      col_nxt = col_in + CIW'(1);
    end
  end

  always_comb begin
    nb_up = 1'b0;
    nb_dn = 1'b0;
    for (int k = 0; k < MAX_COLS; k++) begin
      if (cols_m1 == CIW'(k)) begin
        nb_up = win[MAX_COLS-1-k];
        nb_dn = win[MAX_COLS+1+k];
      end
    end
    nb_any = nb_up || nb_dn
          || (win[MAX_COLS-1] && (col_r != '0))
          || (win[MAX_COLS+1] && (col_r != cols_m1));
    grow   = ctrl.spread && fresh && !reached_r && nb_any;
  end

  always_comb begin
    acc_nxt.bad   = acc_in.bad || (fresh && !reached_r);
    acc_nxt.worst = acc_in.worst;
    if (fresh && reached_r && (dist_r > acc_in.worst)) begin
      acc_nxt.worst = dist_r;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
    acc_r <= acc_nxt;
    if (ctrl.load_we && (load_pos == TW'(IDX))) begin
      kind_r <= kind_in;
    end
    if (ctrl.init) begin
      reached_r <= rotten;
      dist_r    <= '0;
    end else if (grow) begin
      reached_r <= 1'b1;
      dist_r    <= ctrl.step_dist;
    end
  end

  assign col_out = col_r;
  assign reached = reached_r;
  assign acc_out = acc_r;

endmodule

`default_nettype wire

>>> hw/rtl/gmsst_ctrl.sv
`default_nettype none

module gmsst_ctrl #(
  parameter int CELLS = 256,
  localparam int TW   = $clog2(CELLS + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_last_cell,
  output logic                                  in_stall,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gmsst_pkg::MINUTES_W-1:0] out_minutes_needed,
  input  logic                                  cfg_we,
  input  logic [TW-1:0]                         total,
  output logic [TW-1:0]                         load_pos,
  output gmsst_pkg::cell_ctrl_t                 ctrl,
  input  gmsst_pkg::acc_t                       acc
);
  import gmsst_pkg::*;

  phase_t                state_r, state_nxt;
  logic [TW-1:0]         cnt_r, cnt_nxt;
  logic [TW-1:0]         load_pos_r, load_pos_nxt;
  logic [TW-1:0]         settle_r, settle_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [MINUTES_W-1:0]  out_min_r;
  logic [TW:0]           step_next;
  logic                  accept, store, cnt_last, settle_done, out_free, emit;

  assign cnt_last    = (cnt_r == TW'(CELLS - 1));
  assign settle_done = (settle_r == TW'(CELLS));
  assign out_free    = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PH_LOAD: begin
        if (in_valid && in_last_cell) state_nxt = PH_INIT;
      end
      PH_INIT: begin
        state_nxt = PH_SETTLE;
      end
      PH_SETTLE: begin
        if (settle_done) state_nxt = PH_SPREAD;
      end
      PH_SPREAD: begin
        if (cnt_last) state_nxt = PH_REDUCE;
      end
      PH_REDUCE: begin
        if (cnt_last) state_nxt = PH_DONE;
      end
      PH_DONE: begin
        if (out_free) state_nxt = PH_LOAD;
      end
      default: begin
        state_nxt = PH_LOAD;
      end
    endcase
  end

  always_comb begin
    in_stall  = (state_r != PH_LOAD);
    accept    = in_valid && !in_stall;
    store     = accept && (load_pos_r < total);
    emit      = (state_r == PH_DONE) && out_free;
    step_next = {1'b0, cnt_r} + (TW+1)'(1);

    ctrl.load_we   = store;
    ctrl.init      = (state_r == PH_INIT);
    ctrl.spread    = (state_r == PH_SPREAD);
    if (int'(step_next) > int'(DIST_MAX)) begin
      ctrl.step_dist = DIST_MAX;
    end else begin
      ctrl.step_dist = DIST_W'(step_next);
    end
  end

  always_comb begin
    cnt_nxt = '0;
    if (((state_r == PH_SPREAD) || (state_r == PH_REDUCE)) && !cnt_last) begin
      cnt_nxt = cnt_r + TW'(1);
    end

    load_pos_nxt = load_pos_r;
    if (emit) begin
      load_pos_nxt = '0;
    end else if (store) begin
      load_pos_nxt = load_pos_r + TW'(1);
    end

    settle_nxt = settle_r;
    if (cfg_we) begin
      settle_nxt = '0;
    end else if (!settle_done) begin
      settle_nxt = settle_r + TW'(1);
    end

    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_LOAD;
      cnt_r       <= '0;
      load_pos_r  <= '0;
      settle_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      load_pos_r  <= load_pos_nxt;
      settle_r    <= settle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_min_r <= acc.bad ? MINUTES_FAIL : {1'b0, acc.worst};
    end
  end

  assign load_pos           = load_pos_r;
  assign out_valid          = out_valid_r;
  assign out_minutes_needed = out_min_r;

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_cell) |=> (state_r == PH_INIT))
    else $error("last cell did not start the spread");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == PH_DONE))
    else $error("result raised outside of the done phase");

  a_spread_length: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == PH_SPREAD) && (state_nxt == PH_REDUCE)) |-> cnt_last)
    else $error("spread phase ended early");

  a_cfg_resettle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (settle_r == '0))
    else $error("configuration write did not restart column settling");

endmodule

`default_nettype wire

>>> verif/tb_grid_multi_source_spread_time.sv
module tb_grid_multi_source_spread_time;
  import gmsst_pkg::*;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int SETTLE_CYCLES = 800;
  localparam int HOLD_CYCLES = 3000;
  localparam int RANDOM_CELLS = 650;
  localparam int MIN_RESULTS = 40;
  localparam int PHASE_CELLS = 50;
  localparam int UNREACHED = 'hFFFF;
  localparam int DIST_CAP = 255;
  localparam kind_t KIND_SPARE = 2'd3;

  typedef logic signed [MINUTES_W-1:0] minutes_t;
  typedef enum logic [1:0] {DO_CELL, DO_ROWS, DO_COLS} plan_op_t;
  typedef struct packed {
    plan_op_t  op;
    kind_t     kind;
    logic      last;
    cfg_data_t size;
    logic      typed;
    minutes_t  minutes;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  kind_t     in_cell_kind;
  logic      in_last_cell;
  logic      out_valid;
  logic      out_stall;
  minutes_t  out_minutes_needed;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  kind_t      grid_mem [CELLS];
  int         dist_of [CELLS];
  int         wave [CELLS];
  int         grid_fill = 0;
  cfg_data_t  rows_reg = CFG_SIZE_RESET;
  cfg_data_t  cols_reg = CFG_SIZE_RESET;
  minutes_t   minutes_q [$];
  int         errors = 0;
  int         results_due = 0;
  int         cells_taken = 0;
  bit         burst = 1'b0;
  bit         hold_pending = 1'b0;
  plan_row_t  plan [32];

  grid_multi_source_spread_time dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cell_kind       (in_cell_kind),
    .in_last_cell       (in_last_cell),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_minutes_needed (out_minutes_needed),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_size(cfg_data_t v, int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function automatic kind_t cell_at(int idx);
    return (idx < grid_fill) ? grid_mem[idx] : KIND_EMPTY;
  endfunction

  function automatic minutes_t spread_minutes(int rows, int cols);
    int i, d, head, tail, cur, r, c, nr, nc, nidx, worst;
    head = 0;
    tail = 0;
    worst = 0;
    for (i = 0; i < rows * cols; i++) begin
      dist_of[i] = UNREACHED;
      if (cell_at(i) == KIND_ROTTEN) begin
        dist_of[i] = 0;
        wave[tail] = i;
        tail++;
      end
    end
    while (head < tail) begin
      cur = wave[head];
      head++;
      r = cur / cols;
      c = cur % cols;
      for (d = 0; d < 4; d++) begin
        nr = r + int'(d == 1) - int'(d == 0);
        nc = c + int'(d == 3) - int'(d == 2);
        if (nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
          nidx = nr * cols + nc;
          if (cell_at(nidx) == KIND_FRESH && dist_of[nidx] == UNREACHED) begin
            dist_of[nidx] = dist_of[cur] + 1;
            wave[tail] = nidx;
            tail++;
          end
        end
      end
    end
    for (i = 0; i < rows * cols; i++) begin
      if (cell_at(i) == KIND_FRESH) begin
        if (dist_of[i] == UNREACHED) return minutes_t'(-1);
        if (dist_of[i] > worst) worst = dist_of[i];
      end
    end
    if (worst > DIST_CAP) worst = DIST_CAP;
    return minutes_t'(worst);
  endfunction

  function automatic void take_cell(kind_t k, logic lst, logic typed, minutes_t typed_min);
    int rows, cols;
    minutes_t got;
    rows = clamp_size(rows_reg, MAX_ROWS);
    cols = clamp_size(cols_reg, MAX_COLS);
    if (grid_fill < rows * cols) begin
      grid_mem[grid_fill] = k;
      grid_fill++;
      cells_taken++;
    end
    if (lst) begin
      got = spread_minutes(rows, cols);
      minutes_q.insert(minutes_q.size(), typed ? typed_min : got);
      results_due++;
      grid_fill = 0;
    end
  endfunction

  task automatic send_cell(kind_t k, logic lst, logic typed, minutes_t typed_min);
    int r, gap;
    in_valid <= 1'b1;
    in_cell_kind <= k;
    in_last_cell <= lst;
    do @(posedge clk); while (in_stall);
    take_cell(k, lst, typed, typed_min);
    r = $urandom_range(0, 99);
    if (burst || r < 45) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 80);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_size(cfg_idx_t idx, cfg_data_t val);
    in_valid <= 1'b0;
    while (minutes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_ROWS) rows_reg = val;
    else cols_reg = val;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (minutes_q.size() == 0) begin
        $display("%0t: unexpected request, expected none, got %0d", $time,
                 out_minutes_needed);
        errors++;
      end else if (out_minutes_needed !== minutes_q[0]) begin
        $display("%0t: minutes_needed expected %0d, got %0d", $time, minutes_q[0],
                 out_minutes_needed);
        errors++;
        void'(minutes_q.pop_front());
      end else begin
        void'(minutes_q.pop_front());
      end
    end
  end

  initial begin
    int r;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        out_stall <= (r >= 50);
        if (r < 50) repeat ($urandom_range(1, 30)) @(posedge clk);
        else if (r < 90) repeat ($urandom_range(1, 3)) @(posedge clk);
        else repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  initial begin
    #60000000;
    $display("[grid_multi_source_spread_time] ERROR");
    $finish;
  end

  initial begin
    int j, p, i, n, total, shape, rk, src, row, col, phase_start;
    cfg_data_t rows_w, cols_w;
    kind_t k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cell_kind = KIND_EMPTY;
    in_last_cell = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_GRID_ROWS;
    cfg_wdata = '0;
    plan = '{
      '{DO_CELL, KIND_ROTTEN, 1'b1, 5'd0,  1'b1, 9'sd0},
      '{DO_CELL, KIND_FRESH,  1'b1, 5'd0,  1'b1, -9'sd1},
      '{DO_ROWS, KIND_EMPTY,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_COLS, KIND_EMPTY,  1'b0, 5'd3,  1'b0, 9'sd0},
      '{DO_CELL, KIND_ROTTEN, 1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_FRESH,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_FRESH,  1'b1, 5'd0,  1'b1, 9'sd2},
      '{DO_CELL, KIND_FRESH,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_SPARE,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_ROTTEN, 1'b1, 5'd0,  1'b1, -9'sd1},
      '{DO_CELL, KIND_EMPTY,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_EMPTY,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_EMPTY,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_FRESH,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_ROTTEN, 1'b1, 5'd0,  1'b1, 9'sd0},
      '{DO_ROWS, KIND_EMPTY,  1'b0, 5'd31, 1'b0, 9'sd0},
      '{DO_COLS, KIND_EMPTY,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_ROTTEN, 1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_FRESH,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_FRESH,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_FRESH,  1'b1, 5'd0,  1'b1, 9'sd3},
      '{DO_ROWS, KIND_EMPTY,  1'b0, 5'd2,  1'b0, 9'sd0},
      '{DO_COLS, KIND_EMPTY,  1'b0, 5'd2,  1'b0, 9'sd0},
      '{DO_CELL, KIND_FRESH,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_EMPTY,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_EMPTY,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_ROTTEN, 1'b1, 5'd0,  1'b1, -9'sd1},
      '{DO_CELL, KIND_FRESH,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_CELL, KIND_FRESH,  1'b0, 5'd0,  1'b0, 9'sd0},
      '{DO_ROWS, KIND_EMPTY,  1'b0, 5'd1,  1'b0, 9'sd0},
      '{DO_COLS, KIND_EMPTY,  1'b0, 5'd4,  1'b0, 9'sd0},
      '{DO_CELL, KIND_ROTTEN, 1'b1, 5'd0,  1'b1, 9'sd2}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (j = 0; j < 32; j++) begin
      case (plan[j].op)
        DO_ROWS: write_size(CFG_GRID_ROWS, plan[j].size);
        DO_COLS: write_size(CFG_GRID_COLS, plan[j].size);
        default: send_cell(plan[j].kind, plan[j].last, plan[j].typed, plan[j].minutes);
      endcase
    end

    cells_taken = 0;
    results_due = 0;
    for (p = 0; cells_taken < RANDOM_CELLS || results_due < MIN_RESULTS; p++) begin
      if (p == 0) begin
        rows_w = 16;
        cols_w = 16;
      end else if (p == 1) begin
        rows_w = 2;
        cols_w = 2;
      end else begin
        case ($urandom_range(0, 7))
          0: begin
            rows_w = 1;
            cols_w = 1;
          end
          1: begin
            rows_w = 1;
            cols_w = 16;
          end
          2: begin
            rows_w = 16;
            cols_w = 1;
          end
          3: begin
            rows_w = cfg_data_t'($urandom_range(17, 31));
            cols_w = cfg_data_t'($urandom_range(0, 1));
          end
          4: begin
            rows_w = 0;
            cols_w = cfg_data_t'($urandom_range(0, 31));
          end
          default: begin
            rows_w = cfg_data_t'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 10 : 5));
            cols_w = cfg_data_t'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 10 : 5));
          end
        endcase
      end
      write_size(CFG_GRID_ROWS, rows_w);
      write_size(CFG_GRID_COLS, cols_w);
      total = clamp_size(rows_w, MAX_ROWS) * clamp_size(cols_w, MAX_COLS);
      // The receiver holds off while small grids keep coming, so results back up.
      if (p == 1) hold_pending = 1'b1;
      if (p == 0) begin
        // A serpentine of fresh cells gives a long spread on the full grid.
        burst = 1'b0;
        src = $urandom_range(0, 7) * 2 * MAX_COLS + $urandom_range(0, MAX_COLS - 1);
        for (i = 0; i < total; i++) begin
          row = i / MAX_COLS;
          col = i % MAX_COLS;
          if (i == src) k = KIND_ROTTEN;
          else if (row % 2 == 0 || (row % 4 == 1 && col == MAX_COLS - 1) ||
                   (row % 4 == 3 && col == 0)) k = KIND_FRESH;
          else k = KIND_EMPTY;
          send_cell(k, i == total - 1, 1'b0, '0);
        end
      end
      phase_start = cells_taken;
      while (cells_taken - phase_start < PHASE_CELLS) begin
        burst = ($urandom_range(0, 3) == 0);
        shape = $urandom_range(0, 9);
        if (shape == 0) n = $urandom_range(1, 3);
        else if (shape == 1 || total > 64) n = $urandom_range(1, (total > 12) ? 12 : total);
        else if (shape == 2) n = total + $urandom_range(1, 3);
        else n = total;
        for (i = 0; i < n; i++) begin
          rk = $urandom_range(0, 99);
          if (rk < 10) k = KIND_EMPTY;
          else if (rk < 13) k = KIND_SPARE;
          else if (rk < 80) k = KIND_FRESH;
          else k = KIND_ROTTEN;
          send_cell(k, shape != 0 && i == n - 1, 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (minutes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[grid_multi_source_spread_time] OK");
    end else begin
      $display("[grid_multi_source_spread_time] ERROR");
    end
    $finish;
  end

endmodule
